// File: rtl/orq_pkg.sv
package orq_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SLOT_W  = 4;
  localparam int LEN_W   = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Length after reset, clipped to the slot count.
  localparam int LEN_RESET = (16 > DEPTH) ? DEPTH : 16;

  typedef enum logic [1:0] {
    ACT_PUSH      = 2'd0,
    ACT_POP       = 2'd1,
    ACT_PEEK_HEAD = 2'd2,
    ACT_PEEK_SLOT = 2'd3
  } action_e;

  // Register index in the config map.
  localparam logic [PADDR_W-3:0] REG_QUEUE_LENGTH = '0;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // capture the incoming beat
    logic exec;   // access the store, update pointers
  } ctl_cmd_t;

endpackage

// File: rtl/orq_ram.sv
module orq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/orq_ctrl.sv
module orq_ctrl
  import orq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output logic     done_o,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign done_o    = (state_q == ST_RESP);
  assign cmd_o.load = (state_q == ST_IDLE) && start_i;
  assign cmd_o.exec = (state_q == ST_EXEC);

endmodule

// File: rtl/orq_dp.sv
module orq_dp
  import orq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_cmd_t            cmd_i,
  input  logic [1:0]          action_i,
  input  logic [DATA_W-1:0]   item_data_i,
  input  logic [SLOT_W-1:0]   slot_index_i,
  input  logic                cfg_we_i,
  input  logic [LEN_W-1:0]    cfg_len_i,
  output logic [CNT_W-1:0]    len_o,
  output logic [DATA_W-1:0]   result_data_o,
  output logic                result_valid_o,
  output logic                overwrote_o,
  output logic [CNT_W-1:0]    item_count_o,
  output logic                queue_empty_o,
  output logic                queue_full_o
);

  action_e             act_q;
  logic [DATA_W-1:0]   data_q;
  logic [SLOT_W-1:0]   idx_q;
  logic [PTR_W-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d, len_q, len_d;
  logic [DEPTH-1:0]    occ_q, occ_d;
  logic                rvalid_q, rvalid_d, drop_q, drop_d;
  logic [PTR_W-1:0]    head_nx, tail_nx;
  logic                is_full, is_empty, slot_hit;
  logic                ram_we;
  logic [PTR_W-1:0]    ram_waddr, ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  // Wrap at the configured length, not at the slot count.
  function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p,
                                           input logic [CNT_W-1:0] len);
    logic [PTR_W:0] n;
    n = {1'b0, p} + 1'b1;
    return (CNT_W'(n) >= len) ? '0 : n[PTR_W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_e'(action_i);
      data_q <= item_data_i;
      idx_q  <= slot_index_i;
    end
  end

  assign head_nx  = nxt(head_q, len_q);
  assign tail_nx  = nxt(tail_q, len_q);
  assign is_full  = (cnt_q >= len_q);
  assign is_empty = (cnt_q == '0);
  assign slot_hit = !is_empty && (CNT_W'(idx_q) < len_q) && (int'(idx_q) < DEPTH)
                    && occ_q[idx_q[PTR_W-1:0]];

  assign ram_we    = cmd_i.exec && (act_q == ACT_PUSH);
  assign ram_waddr = is_full ? head_q : tail_q;
  assign ram_raddr = (act_q == ACT_PEEK_SLOT) ? idx_q[PTR_W-1:0] : head_q;

  orq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    occ_d    = occ_q;
    rvalid_d = rvalid_q;
    drop_d   = drop_q;
    if (cfg_we_i) begin
      if (cfg_len_i == '0) begin
        len_d = CNT_W'(1);
      end else if (int'(cfg_len_i) > DEPTH) begin
        len_d = CNT_W'(DEPTH);
      end else begin
        len_d = CNT_W'(cfg_len_i);
      end
      head_d = '0;
      tail_d = '0;
      cnt_d  = '0;
      occ_d  = '0;
    end else if (cmd_i.exec) begin
      rvalid_d = 1'b0;
      drop_d   = 1'b0;
      case (act_q)
        ACT_PUSH: begin
          if (is_full) begin
            occ_d[head_q] = 1'b1;
            head_d        = head_nx;
            tail_d        = head_nx;
            drop_d        = 1'b1;
          end else begin
            occ_d[tail_q] = 1'b1;
            tail_d        = tail_nx;
            cnt_d         = cnt_q + 1'b1;
          end
        end
        ACT_POP: begin
          if (!is_empty) begin
            rvalid_d      = 1'b1;
            occ_d[head_q] = 1'b0;
            cnt_d         = cnt_q - 1'b1;
            if (cnt_q == CNT_W'(1)) begin
              head_d = '0;
              tail_d = '0;
            end else begin
              head_d = head_nx;
            end
          end
        end
        ACT_PEEK_HEAD: rvalid_d = !is_empty;
        default:       rvalid_d = slot_hit;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      len_q    <= CNT_W'(LEN_RESET);
      occ_q    <= '0;
      rvalid_q <= 1'b0;
      drop_q   <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      occ_q    <= occ_d;
      rvalid_q <= rvalid_d;
      drop_q   <= drop_d;
    end
  end

  assign len_o          = len_q;
  assign result_data_o  = rvalid_q ? ram_rdata : '0;
  assign result_valid_o = rvalid_q;
  assign overwrote_o    = drop_q;
  assign item_count_o   = cnt_q;
  assign queue_empty_o  = (cnt_q == '0);
  assign queue_full_o   = (cnt_q == len_q);

endmodule

// File: rtl/overwriting_ring_queue.sv
// Channel   Direction  Handshake                      Beat
// command   in         start & !busy at clk edge      action, item_data, slot_index
// result    out        done_o high for one cycle      data, valid, overwrote, count, flags
// config    in/out     APB, psel&penable&pwrite       queue_length at byte address 0
//
// Each command runs through accept, store access and result. The store
// has a registered read port, so the result beat comes in the cycle after
// the access cycle; busy stays high until the result cycle is over.
// Reset empties the queue and sets the length to 16. Results cannot be
// stalled: done_o marks the only cycle a result is shown.
//
// Controller: a three-state sequencer (idle, exec, resp).
// Datapath: pointers, entry count, per-slot occupied flags and a 16x32
// RAM for the words. Writing queue_length clamps it to 1..16 and empties
// the queue; the RAM itself is never cleared, the occupied flags and the
// count guard every read of it.
module overwriting_ring_queue
  import orq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // command
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action_i,
  input  logic [DATA_W-1:0]  item_data_i,
  input  logic [SLOT_W-1:0]  slot_index_i,
  // result
  output logic               done_o,
  output logic [DATA_W-1:0]  result_data_o,
  output logic               result_valid_o,
  output logic               overwrote_o,
  output logic [CNT_W-1:0]   item_count_o,
  output logic               queue_empty_o,
  output logic               queue_full_o,
  // config
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  ctl_cmd_t         cmd;
  logic             reg_sel;
  logic             cfg_we;
  logic [CNT_W-1:0] len;

  // Word-aligned decode; byte offset bits are ignored.
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_QUEUE_LENGTH);
  assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? PDATA_W'(len) : '0;

  orq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  orq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (action_i),
    .item_data_i    (item_data_i),
    .slot_index_i   (slot_index_i),
    .cfg_we_i       (cfg_we),
    .cfg_len_i      (pwdata[LEN_W-1:0]),
    .len_o          (len),
    .result_data_o  (result_data_o),
    .result_valid_o (result_valid_o),
    .overwrote_o    (overwrote_o),
    .item_count_o   (item_count_o),
    .queue_empty_o  (queue_empty_o),
    .queue_full_o   (queue_full_o)
  );

endmodule

// File: rtl/orq_checker.sv
module orq_checker
  import orq_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic [DATA_W-1:0] result_data_o,
  input logic              result_valid_o,
  input logic              overwrote_o,
  input logic              queue_full_o
);

  // Accepted command yields its result in the resp state that follows exec.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##1 done_o)
    else $error("result beat missing after accept");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result beat while idle");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && overwrote_o |-> queue_full_o && !result_valid_o)
    else $error("drop reported without full queue");

  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_valid_o |-> result_data_o == '0)
    else $error("invalid result carries data");

endmodule

bind overwriting_ring_queue orq_checker u_orq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .result_data_o  (result_data_o),
  .result_valid_o (result_valid_o),
  .overwrote_o    (overwrote_o),
  .queue_full_o   (queue_full_o)
);
